@@ rtl/core/assert_macros.svh @@
// Assertion helper macros for the MIDI track event parser.
// Included by the module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked at every edge, reset included.
`define AST_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/mtep_pkg.sv @@
// Shared types, codes and helper functions for the MIDI track event parser.
// No dependencies; used by every module in rtl/core.
package mtep_pkg;

    // Parser phases
    localparam logic [3:0] PH_DELTA  = 4'd0;
    localparam logic [3:0] PH_STATUS = 4'd1;
    localparam logic [3:0] PH_KEY    = 4'd2;
    localparam logic [3:0] PH_VEL    = 4'd3;
    localparam logic [3:0] PH_CNUM   = 4'd4;
    localparam logic [3:0] PH_CVAL   = 4'd5;
    localparam logic [3:0] PH_SKIP   = 4'd6;
    localparam logic [3:0] PH_MTYPE  = 4'd7;
    localparam logic [3:0] PH_MLEN   = 4'd8;
    localparam logic [3:0] PH_MDATA  = 4'd9;

    // Last channel event, for running status
    localparam logic [2:0] CK_NONE = 3'd0;
    localparam logic [2:0] CK_OFF  = 3'd1;
    localparam logic [2:0] CK_ON   = 3'd2;
    localparam logic [2:0] CK_CTRL = 3'd3;
    localparam logic [2:0] CK_ONE  = 3'd4;
    localparam logic [2:0] CK_TWO  = 3'd5;

    // Result kinds
    localparam logic [3:0] K_NOTE_OFF = 4'd0;
    localparam logic [3:0] K_NOTE_ON  = 4'd1;
    localparam logic [3:0] K_BRIGHT   = 4'd2;
    localparam logic [3:0] K_CTRL     = 4'd3;
    localparam logic [3:0] K_TEMPO    = 4'd4;
    localparam logic [3:0] K_TSIG     = 4'd5;
    localparam logic [3:0] K_END      = 4'd6;
    localparam logic [3:0] K_COLOUR   = 4'd7;
    localparam logic [3:0] K_OTHER    = 4'd8;

    // Status high nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_KEY_PRES = 4'hA;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_PROGRAM  = 4'hC;
    localparam logic [3:0] ST_CHAN_PRS = 4'hD;
    localparam logic [3:0] ST_BEND     = 4'hE;

    // Byte constants
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_ESC   = 8'hF7;
    localparam logic [7:0] CTRL_BREATH = 8'h02;
    localparam logic [7:0] MT_TEMPO    = 8'h51;
    localparam logic [7:0] MT_TSIG     = 8'h58;
    localparam logic [7:0] MT_END      = 8'h2F;
    localparam logic [7:0] MT_LYRIC    = 8'h05;
    localparam logic [7:0] LYRIC_LEN   = 8'd8;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_O        = 8'h4F;
    localparam logic [7:0] CH_L        = 8'h4C;
    localparam logic [2:0] META_KEEP   = 3'd4;

    // Parser state
    typedef struct packed {
        logic [3:0]  phase;
        logic [27:0] delta;
        logic [2:0]  last_ck;
        logic [7:0]  meta_type;
        logic [7:0]  bytes_left;
        logic [31:0] gathered;
        logic [3:0]  hex_hi;
        logic [2:0]  meta_taken;
    } t_state;

    // One result record
    typedef struct packed {
        logic [3:0]  kind;
        logic [27:0] delta_ticks;
        logic [7:0]  key;
        logic [7:0]  level;
        logic [31:0] value;
    } t_result;

    // ASCII hex digit value, 16 when not a digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end
        return d;
    endfunction

    // Colour target code, 0 for an unknown letter
    function automatic logic [2:0] lyric_target(input logic [7:0] c);
        logic [2:0] t;
        t = 3'd0;
        if (c == CH_H) begin
            t = 3'd1;
        end else if (c == CH_I) begin
            t = 3'd2;
        end else if (c == CH_O) begin
            t = 3'd3;
        end else if (c == CH_L) begin
            t = 3'd4;
        end
        return t;
    endfunction

endpackage

@@ rtl/core/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser: input register, state, result register.
// Depends on mtep_pkg, mtep_decode, mtep_out_reg and assert_macros.svh.
//
//  channel   direction  handshake                  payload
//  byte in   input      i_in_valid / o_in_stall    i_byte_in
//  record    output     o_out_valid / i_out_stall  o_kind, o_delta_ticks, o_key,
//                                                  o_level, o_value
//
// One byte per cycle sustained while the output is not stalled; a record passes through
// the input register and then the result register after its last byte.
// The parser state updates from the registered byte.
// Synchronous active-low reset clears the state and both valid flags.
// A stalled output holds the record; the input stalls only once its register is also full.
`include "assert_macros.svh"

module midi_track_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [27:0] o_delta_ticks,
    output logic [7:0]  o_key,
    output logic [7:0]  o_level,
    output logic [31:0] o_value
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    mtep_pkg::t_state  r_st;
    mtep_pkg::t_state  n_st;
    mtep_pkg::t_result w_res;
    mtep_pkg::t_result w_out;
    logic              w_res_vld;
    logic              w_adv;
    logic              w_step;

    // A byte is processed when held and the result register can move
    assign w_step     = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    // Parser step
    mtep_decode u_decode (
        .i_st      (r_st),
        .i_byte    (r_in_byte),
        .o_st      (n_st),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{phase: mtep_pkg::PH_DELTA, last_ck: mtep_pkg::CK_NONE, default: '0};
        end else if (w_step) begin
            r_st <= n_st;
        end
    end

    // Result register
    mtep_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (r_in_vld),
        .i_res_vld (w_res_vld),
        .i_res     (w_res),
        .i_stall   (i_out_stall),
        .o_adv     (w_adv),
        .o_valid   (o_out_valid),
        .o_res     (w_out)
    );

    assign o_kind        = w_out.kind;
    assign o_delta_ticks = w_out.delta_ticks;
    assign o_key         = w_out.key;
    assign o_level       = w_out.level;
    assign o_value       = w_out.value;

    // Checks
    `AST_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, ##1 (!o_out_valid && !r_in_vld))
    `AST_NEXT(a_emit_restarts, i_clk, i_rst_n, w_step && w_res_vld,
              r_st.phase == mtep_pkg::PH_DELTA && r_st.delta == 28'h0)
    `AST_NEXT(a_emit_shows, i_clk, i_rst_n, w_step && w_res_vld, o_out_valid)
    `AST_NEXT(a_stall_freezes, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(r_st))

endmodule

@@ rtl/core/mtep_decode.sv @@
// Per-byte next-state and result logic of the MIDI track event parser.
// Purely combinational; depends on mtep_pkg.
module mtep_decode (
    input  mtep_pkg::t_state  i_st,
    input  logic [7:0]        i_byte,
    output mtep_pkg::t_state  o_st,
    output logic              o_res_vld,
    output mtep_pkg::t_result o_res
);

    mtep_pkg::t_state n_st;
    logic        emit;
    logic        fin;
    logic [3:0]  e_kind;
    logic [7:0]  e_key;
    logic [7:0]  e_level;
    logic [31:0] e_value;
    logic [4:0]  dig;
    logic [2:0]  tgt;
    logic [7:0]  hex_byte;

    assign dig = mtep_pkg::hex_digit(i_byte);
    assign tgt = mtep_pkg::lyric_target(i_byte);
    // Low hex digit completes a colour byte; a bad digit zeroes it
    assign hex_byte = dig[4] ? 8'h00 : {i_st.hex_hi, dig[3:0]};

    // One parser step per byte
    always_comb begin
        n_st    = i_st;
        emit    = 1'b0;
        fin     = 1'b0;
        e_kind  = mtep_pkg::K_OTHER;
        e_key   = 8'h00;
        e_level = 8'h00;
        e_value = 32'h0;

        unique case (i_st.phase)
            mtep_pkg::PH_DELTA: begin
                n_st.delta = {i_st.delta[20:0], i_byte[6:0]};
                if (!i_byte[7]) begin
                    n_st.phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (!i_byte[7]) begin
                    // Running status: data byte of the last channel event
                    unique case (i_st.last_ck)
                        mtep_pkg::CK_OFF, mtep_pkg::CK_ON: begin
                            n_st.gathered = {24'h0, i_byte};
                            n_st.phase    = mtep_pkg::PH_VEL;
                        end
                        mtep_pkg::CK_CTRL: begin
                            n_st.gathered = {31'h0, i_byte == mtep_pkg::CTRL_BREATH};
                            n_st.phase    = mtep_pkg::PH_CVAL;
                        end
                        mtep_pkg::CK_TWO: begin
                            n_st.bytes_left = 8'd1;
                            n_st.phase      = mtep_pkg::PH_SKIP;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end else begin
                    unique case (i_byte[7:4])
                        mtep_pkg::ST_NOTE_OFF: begin
                            n_st.last_ck = mtep_pkg::CK_OFF;
                            n_st.phase   = mtep_pkg::PH_KEY;
                        end
                        mtep_pkg::ST_NOTE_ON: begin
                            n_st.last_ck = mtep_pkg::CK_ON;
                            n_st.phase   = mtep_pkg::PH_KEY;
                        end
                        mtep_pkg::ST_CTRL: begin
                            n_st.last_ck = mtep_pkg::CK_CTRL;
                            n_st.phase   = mtep_pkg::PH_CNUM;
                        end
                        mtep_pkg::ST_PROGRAM, mtep_pkg::ST_CHAN_PRS: begin
                            n_st.last_ck    = mtep_pkg::CK_ONE;
                            n_st.bytes_left = 8'd1;
                            n_st.phase      = mtep_pkg::PH_SKIP;
                        end
                        mtep_pkg::ST_KEY_PRES, mtep_pkg::ST_BEND: begin
                            n_st.last_ck    = mtep_pkg::CK_TWO;
                            n_st.bytes_left = 8'd2;
                            n_st.phase      = mtep_pkg::PH_SKIP;
                        end
                        default: begin
                            // System bytes: sysex has no type byte
                            if (i_byte == mtep_pkg::SYSEX_START ||
                                i_byte == mtep_pkg::SYSEX_ESC) begin
                                n_st.meta_type = 8'h00;
                                n_st.phase     = mtep_pkg::PH_MLEN;
                            end else begin
                                n_st.phase = mtep_pkg::PH_MTYPE;
                            end
                        end
                    endcase
                end
            end
            mtep_pkg::PH_KEY: begin
                n_st.gathered = {24'h0, i_byte};
                n_st.phase    = mtep_pkg::PH_VEL;
            end
            mtep_pkg::PH_VEL: begin
                emit  = 1'b1;
                e_key = i_st.gathered[7:0];
                if (i_st.last_ck == mtep_pkg::CK_ON) begin
                    e_kind  = mtep_pkg::K_NOTE_ON;
                    e_level = i_byte;
                end else begin
                    e_kind = mtep_pkg::K_NOTE_OFF;
                end
            end
            mtep_pkg::PH_CNUM: begin
                n_st.gathered = {31'h0, i_byte == mtep_pkg::CTRL_BREATH};
                n_st.phase    = mtep_pkg::PH_CVAL;
            end
            mtep_pkg::PH_CVAL: begin
                emit = 1'b1;
                if (i_st.gathered != 32'h0) begin
                    e_kind = mtep_pkg::K_BRIGHT;
                    e_key  = i_byte;
                end else begin
                    e_kind = mtep_pkg::K_CTRL;
                end
            end
            mtep_pkg::PH_SKIP: begin
                if (i_st.bytes_left <= 8'd1) begin
                    emit = 1'b1;
                end else begin
                    n_st.bytes_left = i_st.bytes_left - 8'd1;
                end
            end
            mtep_pkg::PH_MTYPE: begin
                n_st.meta_type = i_byte;
                n_st.phase     = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN: begin
                n_st.bytes_left = i_byte;
                n_st.meta_taken = 3'd0;
                n_st.gathered   = 32'h0;
                n_st.hex_hi     = 4'h0;
                if (i_st.meta_type == mtep_pkg::MT_LYRIC && i_byte != mtep_pkg::LYRIC_LEN) begin
                    n_st.meta_type = 8'h00;
                end
                if (i_byte == 8'h00) begin
                    fin = 1'b1;
                end else begin
                    n_st.phase = mtep_pkg::PH_MDATA;
                end
            end
            mtep_pkg::PH_MDATA: begin
                // Tempo and time signature keep their first four bytes
                if (i_st.meta_type == mtep_pkg::MT_TEMPO ||
                    i_st.meta_type == mtep_pkg::MT_TSIG) begin
                    if (i_st.meta_taken < mtep_pkg::META_KEEP) begin
                        n_st.gathered   = {i_st.gathered[23:0], i_byte};
                        n_st.meta_taken = i_st.meta_taken + 3'd1;
                    end
                end else if (i_st.meta_type == mtep_pkg::MT_LYRIC) begin
                    // Colour lyric: target letter, separator, six hex digits
                    if (i_st.bytes_left == mtep_pkg::LYRIC_LEN) begin
                        if (tgt == 3'd0) begin
                            n_st.meta_type = 8'h00;
                        end else begin
                            n_st.gathered = {5'h0, tgt, 24'h0};
                        end
                    end else if (i_st.bytes_left <= 8'd6 && i_st.bytes_left != 8'd0) begin
                        if (!i_st.bytes_left[0]) begin
                            n_st.hex_hi = dig[4] ? 4'h0 : dig[3:0];
                        end else begin
                            n_st.gathered = {i_st.gathered[31:24], i_st.gathered[15:0],
                                             hex_byte};
                        end
                    end
                end
                if (i_st.bytes_left != 8'd0) begin
                    n_st.bytes_left = i_st.bytes_left - 8'd1;
                end
                if (n_st.bytes_left == 8'd0) begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_st.phase = mtep_pkg::PH_DELTA;
            end
        endcase

        // Close a meta or sysex event
        if (fin) begin
            emit = 1'b1;
            unique case (n_st.meta_type)
                mtep_pkg::MT_END: begin
                    e_kind = mtep_pkg::K_END;
                end
                mtep_pkg::MT_TEMPO: begin
                    e_kind  = mtep_pkg::K_TEMPO;
                    e_value = n_st.gathered;
                end
                mtep_pkg::MT_TSIG: begin
                    e_kind  = mtep_pkg::K_TSIG;
                    e_value = n_st.gathered;
                end
                mtep_pkg::MT_LYRIC: begin
                    e_kind  = mtep_pkg::K_COLOUR;
                    e_key   = n_st.gathered[31:24];
                    e_value = {8'h00, n_st.gathered[23:0]};
                end
                default: begin
                    e_kind = mtep_pkg::K_OTHER;
                end
            endcase
        end

        // Every record restarts delta decoding
        if (emit) begin
            n_st.phase = mtep_pkg::PH_DELTA;
            n_st.delta = 28'h0;
        end
    end

    assign o_st              = n_st;
    assign o_res_vld         = emit;
    assign o_res.kind        = e_kind;
    assign o_res.delta_ticks = i_st.delta;
    assign o_res.key         = e_key;
    assign o_res.level       = e_level;
    assign o_res.value       = e_value;

endmodule

@@ rtl/core/mtep_out_reg.sv @@
// Result register of the MIDI track event parser with valid/stall handshake.
// Depends on mtep_pkg for the result record type.
module mtep_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_res_vld,
    input  mtep_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_adv,
    output logic              o_valid,
    output mtep_pkg::t_result o_res
);

    logic              r_vld;
    mtep_pkg::t_result r_res;

    // Register may take a new record when empty or being drained
    assign o_adv = !r_vld || !i_stall;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_take && i_res_vld;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_adv && i_take && i_res_vld) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule
